@@ rtl/core/sbe_pkg.sv @@
package sbe_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OPC_W = 4;
  localparam int unsigned SLOT_W = 8;
  localparam int unsigned STACK_WORDS_DEF = 256;
  localparam int unsigned FRAME_SLOTS_DEF = 256;

  typedef enum logic [OPC_W-1:0] {
    OP_NOP = 4'd0,
    OP_LIT = 4'd1,
    OP_GET = 4'd2,
    OP_SET = 4'd3,
    OP_POP = 4'd4,
    OP_ADD = 4'd5,
    OP_SUB = 4'd6,
    OP_MUL = 4'd7,
    OP_DIV = 4'd8,
    OP_MOD = 4'd9,
    OP_NEG = 4'd10,
    OP_RET = 4'd11
  } op_e;

  typedef enum logic [1:0] {
    FAULT_OK       = 2'd0,
    FAULT_UNDER    = 2'd1,
    FAULT_OVER     = 2'd2,
    FAULT_DIV_ZERO = 2'd3
  } fault_e;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_NEG,
    ALU_MUL,
    ALU_DIV,
    ALU_MOD
  } alu_op_e;

  typedef struct packed {
    logic              start;
    alu_op_e           op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

@@ rtl/core/sbe_ram.sv @@
module sbe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/sbe_alu.sv @@
module sbe_alu
  import sbe_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    A_IDLE,
    A_ONE,
    A_ABS_A,
    A_ABS_B,
    A_RUN,
    A_FIX,
    A_DONE
  } alu_state_e;

  localparam int unsigned CNT_W = $clog2(DATA_W);

  alu_state_e        state_q;
  alu_op_e           op_q;
  logic [DATA_W-1:0] a_q;
  logic [DATA_W-1:0] b_q;
  logic [DATA_W-1:0] acc_q;
  logic [DATA_W-1:0] res_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              neg_q;

  // Shared adder: x + (y ^ inv) + inv
  logic [DATA_W:0]   add_x;
  logic [DATA_W:0]   add_y;
  logic              add_inv;
  logic [DATA_W+1:0] add_sum;
  logic [DATA_W:0]   div_shift;
  logic [DATA_W-1:0] fix_val;

  assign div_shift = {acc_q, a_q[DATA_W-1]};
  assign fix_val   = (op_q == ALU_DIV) ? a_q : acc_q;

  // Select adder operands for the current step
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_inv = 1'b0;
    case (state_q)
      A_ONE: begin
        case (op_q)
          ALU_ADD: begin
            add_x = {1'b0, a_q};
            add_y = {1'b0, b_q};
          end
          ALU_SUB: begin
            add_x   = {1'b0, a_q};
            add_y   = {1'b0, b_q};
            add_inv = 1'b1;
          end
          default: begin
            add_y   = {1'b0, a_q};
            add_inv = 1'b1;
          end
        endcase
      end
      A_ABS_A: begin
        add_y   = {1'b0, a_q};
        add_inv = 1'b1;
      end
      A_ABS_B: begin
        add_y   = {1'b0, b_q};
        add_inv = 1'b1;
      end
      A_RUN: begin
        if (op_q == ALU_MUL) begin
          add_x = {1'b0, acc_q};
          add_y = {1'b0, b_q};
        end else begin
          add_x   = div_shift;
          add_y   = {1'b0, b_q};
          add_inv = 1'b1;
        end
      end
      A_FIX: begin
        add_y   = {1'b0, fix_val};
        add_inv = 1'b1;
      end
      default: begin
        add_inv = 1'b0;
      end
    endcase
  end

  assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {(DATA_W+1){add_inv}}}
                 + {{(DATA_W+1){1'b0}}, add_inv};

  // Sequence single-step ops, shift-add multiply and restoring divide
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      op_q    <= ALU_ADD;
      a_q     <= '0;
      b_q     <= '0;
      acc_q   <= '0;
      res_q   <= '0;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      case (state_q)
        A_IDLE: begin
          if (req_i.start) begin
            op_q  <= req_i.op;
            a_q   <= req_i.a;
            b_q   <= req_i.b;
            acc_q <= '0;
            cnt_q <= '0;
            neg_q <= 1'b0;
            case (req_i.op)
              ALU_MUL: state_q <= A_RUN;
              ALU_DIV: begin
                neg_q   <= req_i.a[DATA_W-1] ^ req_i.b[DATA_W-1];
                state_q <= A_ABS_A;
              end
              ALU_MOD: begin
                neg_q   <= req_i.a[DATA_W-1];
                state_q <= A_ABS_A;
              end
              default: state_q <= A_ONE;
            endcase
          end
        end
        A_ONE: begin
          res_q   <= add_sum[DATA_W-1:0];
          state_q <= A_DONE;
        end
        A_ABS_A: begin
          if (a_q[DATA_W-1]) begin
            a_q <= add_sum[DATA_W-1:0];
          end
          state_q <= A_ABS_B;
        end
        A_ABS_B: begin
          if (b_q[DATA_W-1]) begin
            b_q <= add_sum[DATA_W-1:0];
          end
          state_q <= A_RUN;
        end
        A_RUN: begin
          if (op_q == ALU_MUL) begin
            if (a_q[0]) begin
              acc_q <= add_sum[DATA_W-1:0];
            end
            a_q <= {1'b0, a_q[DATA_W-1:1]};
            b_q <= {b_q[DATA_W-2:0], 1'b0};
          end else begin
            // Carry out set means the shifted remainder covers the divisor
            if (add_sum[DATA_W+1]) begin
              acc_q <= add_sum[DATA_W-1:0];
              a_q   <= {a_q[DATA_W-2:0], 1'b1};
            end else begin
              acc_q <= div_shift[DATA_W-1:0];
              a_q   <= {a_q[DATA_W-2:0], 1'b0};
            end
          end
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(DATA_W - 1)) begin
            state_q <= A_FIX;
          end
        end
        A_FIX: begin
          res_q   <= neg_q ? add_sum[DATA_W-1:0] : fix_val;
          state_q <= A_DONE;
        end
        A_DONE: begin
          state_q <= A_IDLE;
        end
        default: begin
          state_q <= A_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.done   = (state_q == A_DONE);
  assign rsp_o.result = res_q;

endmodule

@@ rtl/core/stack_bytecode_executor.sv @@
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_stall_o  opcode_i, literal_value_i, slot_index_i
// out      output     out_valid_o / out_stall_i returned_o, return_value_o, fault_o
//
// One instruction at a time: in_stall_o stays high from acceptance until the result is
// registered. Neg, add and sub take a single step in the shared unit; mul, div and mod
// iterate in it as a 32-step unit. A zero divisor faults without starting the unit.
// Reset is asynchronous and active low; it empties the stack and marks every frame
// slot as zero through per-slot valid bits, so no clearing pass is needed.
// A finished result waits in the output register while out_stall_i is high.
module stack_bytecode_executor
  import sbe_pkg::*;
#(
  parameter int unsigned STACK_WORDS = STACK_WORDS_DEF,
  parameter int unsigned FRAME_SLOTS = FRAME_SLOTS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [OPC_W-1:0]         opcode_i,
  input  logic signed [DATA_W-1:0] literal_value_i,
  input  logic [SLOT_W-1:0]        slot_index_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     returned_o,
  output logic signed [DATA_W-1:0] return_value_o,
  output logic [1:0]               fault_o
);

  localparam int unsigned ADDR_W  = $clog2(STACK_WORDS);
  localparam int unsigned DEPTH_W = $clog2(STACK_WORDS + 1);
  localparam int unsigned FIDX_W  = $clog2(FRAME_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD_B,
    S_RD_A,
    S_ALU,
    S_GET,
    S_FINISH
  } state_e;

  state_e             state_q;
  logic [OPC_W-1:0]   opcode_q;
  logic [DATA_W-1:0]  lit_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [DEPTH_W-1:0] depth_q;
  logic [DATA_W-1:0]  opb_q;
  fault_e             fault_q;
  logic               ret_q;
  logic [DATA_W-1:0]  val_q;
  logic [FRAME_SLOTS-1:0] fvalid_q;

  logic               out_valid_q;
  logic               out_ret_q;
  logic [DATA_W-1:0]  out_val_q;
  fault_e             out_fault_q;

  op_e                op;
  logic               is_bin;
  logic               is_div;
  logic               full;
  logic               slot_ok;
  logic [FIDX_W-1:0]  fidx;
  logic [DEPTH_W-1:0] dm1;
  logic [DEPTH_W-1:0] dm2;
  logic               out_free;

  logic               stk_we;
  logic [ADDR_W-1:0]  stk_waddr;
  logic [DATA_W-1:0]  stk_wdata;
  logic [ADDR_W-1:0]  stk_raddr;
  logic [DATA_W-1:0]  stk_rdata;
  logic               frm_we;
  logic [DATA_W-1:0]  frm_rdata;
  logic [DATA_W-1:0]  frm_val;

  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;

  assign op      = op_e'(opcode_q);
  assign is_bin  = op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD};
  assign is_div  = op inside {OP_DIV, OP_MOD};
  assign full    = (depth_q == DEPTH_W'(STACK_WORDS));
  assign slot_ok = ({1'b0, slot_q} < (SLOT_W + 1)'(FRAME_SLOTS));
  assign fidx    = slot_q[FIDX_W-1:0];
  assign dm1     = depth_q - DEPTH_W'(1);
  assign dm2     = depth_q - DEPTH_W'(2);
  assign frm_val = (slot_ok && fvalid_q[fidx]) ? frm_rdata : '0;
  assign out_free = !out_valid_q || !out_stall_i;

  // Stack and frame port control
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = depth_q[ADDR_W-1:0];
    stk_wdata = lit_q;
    case (state_q)
      S_DECODE: stk_we = (op == OP_LIT) && !full;
      S_GET: begin
        stk_we    = 1'b1;
        stk_wdata = frm_val;
      end
      S_ALU: begin
        stk_we    = alu_rsp.done;
        stk_waddr = (op == OP_NEG) ? dm1[ADDR_W-1:0] : dm2[ADDR_W-1:0];
        stk_wdata = alu_rsp.result;
      end
      default: stk_we = 1'b0;
    endcase
  end

  assign stk_raddr = (state_q == S_RD_B) ? dm2[ADDR_W-1:0] : dm1[ADDR_W-1:0];
  assign frm_we    = (state_q == S_RD_B) && (op == OP_SET) && slot_ok;

  // Start the shared unit on neg once the top is read, on binary ops once both are read
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.a     = stk_rdata;
    alu_req.b     = opb_q;
    case (op)
      OP_ADD:  alu_req.op = ALU_ADD;
      OP_SUB:  alu_req.op = ALU_SUB;
      OP_MUL:  alu_req.op = ALU_MUL;
      OP_DIV:  alu_req.op = ALU_DIV;
      OP_MOD:  alu_req.op = ALU_MOD;
      default: alu_req.op = ALU_NEG;
    endcase
    if (state_q == S_RD_B && op == OP_NEG) begin
      alu_req.start = 1'b1;
    end else if (state_q == S_RD_A && !(is_div && opb_q == '0)) begin
      alu_req.start = 1'b1;
    end
  end

  sbe_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_WORDS)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  sbe_ram #(
    .WIDTH(DATA_W),
    .DEPTH(FRAME_SLOTS)
  ) u_frame (
    .clk_i  (clk_i),
    .we_i   (frm_we),
    .waddr_i(fidx),
    .wdata_i(stk_rdata),
    .raddr_i(fidx),
    .rdata_o(frm_rdata)
  );

  sbe_alu u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Sequencer, stack depth, frame valid bits and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      opcode_q    <= '0;
      lit_q       <= '0;
      slot_q      <= '0;
      depth_q     <= '0;
      opb_q       <= '0;
      fault_q     <= FAULT_OK;
      ret_q       <= 1'b0;
      val_q       <= '0;
      fvalid_q    <= '0;
      out_valid_q <= 1'b0;
      out_ret_q   <= 1'b0;
      out_val_q   <= '0;
      out_fault_q <= FAULT_OK;
    end else begin
      // Drop the result once the transaction completes, unless a new one replaces it
      if (out_valid_q && !out_stall_i && state_q != S_FINISH) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            opcode_q <= opcode_i;
            lit_q    <= literal_value_i;
            slot_q   <= slot_index_i;
            fault_q  <= FAULT_OK;
            ret_q    <= 1'b0;
            val_q    <= '0;
            state_q  <= S_DECODE;
          end
        end
        S_DECODE: begin
          state_q <= S_FINISH;
          case (op)
            OP_LIT: begin
              if (full) begin
                fault_q <= FAULT_OVER;
              end else begin
                depth_q <= depth_q + DEPTH_W'(1);
              end
            end
            OP_GET: begin
              if (full) begin
                fault_q <= FAULT_OVER;
              end else begin
                state_q <= S_GET;
              end
            end
            OP_POP: begin
              if (depth_q == '0) begin
                fault_q <= FAULT_UNDER;
              end else begin
                depth_q <= dm1;
              end
            end
            OP_SET, OP_NEG, OP_RET: begin
              if (depth_q == '0) begin
                fault_q <= FAULT_UNDER;
              end else begin
                state_q <= S_RD_B;
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
              if (depth_q < DEPTH_W'(2)) begin
                fault_q <= FAULT_UNDER;
              end else begin
                state_q <= S_RD_B;
              end
            end
            default: state_q <= S_FINISH;
          endcase
        end
        S_RD_B: begin
          case (op)
            OP_SET: begin
              if (slot_ok) begin
                fvalid_q[fidx] <= 1'b1;
              end
              depth_q <= dm1;
              state_q <= S_FINISH;
            end
            OP_RET: begin
              val_q   <= stk_rdata;
              ret_q   <= 1'b1;
              depth_q <= dm1;
              state_q <= S_FINISH;
            end
            OP_NEG: state_q <= S_ALU;
            default: begin
              opb_q   <= stk_rdata;
              state_q <= S_RD_A;
            end
          endcase
        end
        S_RD_A: begin
          if (is_div && opb_q == '0) begin
            fault_q <= FAULT_DIV_ZERO;
            state_q <= S_FINISH;
          end else begin
            state_q <= S_ALU;
          end
        end
        S_ALU: begin
          if (alu_rsp.done) begin
            if (is_bin) begin
              depth_q <= dm1;
            end
            state_q <= S_FINISH;
          end
        end
        S_GET: begin
          depth_q <= depth_q + DEPTH_W'(1);
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          // Hold until the output register is free
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_ret_q   <= ret_q;
            out_val_q   <= val_q;
            out_fault_q <= fault_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign returned_o     = out_ret_q;
  assign return_value_o = out_val_q;
  assign fault_o        = out_fault_q;

endmodule

@@ tb/stack_bytecode_executor_tb.sv @@
module stack_bytecode_executor_tb;
  import sbe_pkg::*;

  localparam int unsigned N_STACK = STACK_WORDS_DEF;
  localparam int unsigned N_SLOTS = FRAME_SLOTS_DEF;
  localparam logic [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] WORD_NEG1 = 32'hFFFF_FFFF;
  localparam logic [OPC_W-1:0] OPC_TOP = {OPC_W{1'b1}};
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned MAX_REPORTS = 200;

  typedef struct {
    logic              returned;
    logic [DATA_W-1:0] value;
    fault_e            fault;
  } outcome_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [OPC_W-1:0]         opcode_i = OP_NOP;
  logic signed [DATA_W-1:0] literal_value_i = '0;
  logic [SLOT_W-1:0]        slot_index_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     returned_o;
  logic signed [DATA_W-1:0] return_value_o;
  logic [1:0]               fault_o;

  // Shadow copy of the machine state, advanced once per accepted instruction
  logic [DATA_W-1:0] shadow_stack [N_STACK];
  logic [DATA_W-1:0] shadow_frame [N_SLOTS];
  int unsigned       shadow_depth;

  outcome_t    outcome_q [$];
  int unsigned mismatch_count = 0;
  int unsigned instr_count = 0;
  int unsigned return_count = 0;
  int unsigned fault_tally [4] = '{default: 0};
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;
  int unsigned hold_cycles_req = 0;

  stack_bytecode_executor #(
    .STACK_WORDS(N_STACK),
    .FRAME_SLOTS(N_SLOTS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .literal_value_i(literal_value_i),
    .slot_index_i   (slot_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .returned_o     (returned_o),
    .return_value_o (return_value_o),
    .fault_o        (fault_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Bias operands toward the corners of signed arithmetic
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'd1;
      2: return WORD_NEG1;
      3: return WORD_MIN;
      4: return WORD_MAX;
      5, 6: return DATA_W'($urandom_range(0, 20)) - 32'd10;
      default: return $urandom();
    endcase
  endfunction

  // Favor a few slots so loads often see stored values
  function automatic logic [SLOT_W-1:0] pick_slot();
    if ($urandom_range(0, 1) == 0) return SLOT_W'($urandom_range(0, 7));
    return SLOT_W'($urandom_range(0, (1 << SLOT_W) - 1));
  endfunction

  // Execute one instruction on the shadow state and queue its outcome
  function automatic void execute_instr(logic [OPC_W-1:0] op, logic [DATA_W-1:0] lit,
                                        logic [SLOT_W-1:0] slot);
    outcome_t          res;
    int unsigned       need;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    longint            sa;
    longint            sb;
    res.returned = 1'b0;
    res.value = '0;
    res.fault = FAULT_OK;
    case (op)
      OP_SET, OP_POP, OP_NEG, OP_RET: need = 1;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: need = 2;
      default: need = 0;
    endcase
    if (need > shadow_depth) begin
      res.fault = FAULT_UNDER;
    end else begin
      case (op)
        OP_LIT, OP_GET: begin
          if (shadow_depth >= N_STACK) begin
            res.fault = FAULT_OVER;
          end else begin
            if (op == OP_LIT) a = lit;
            else a = (slot < N_SLOTS) ? shadow_frame[slot] : '0;
            shadow_stack[shadow_depth] = a;
            shadow_depth++;
          end
        end
        OP_SET: begin
          // An out-of-frame store just drops the word
          if (slot < N_SLOTS) shadow_frame[slot] = shadow_stack[shadow_depth - 1];
          shadow_depth--;
        end
        OP_POP: shadow_depth--;
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
          a = shadow_stack[shadow_depth - 2];
          b = shadow_stack[shadow_depth - 1];
          if ((op == OP_DIV || op == OP_MOD) && b == '0) begin
            res.fault = FAULT_DIV_ZERO;
          end else begin
            // 64-bit signed math makes min / -1 wrap instead of trap
            sa = $signed(a);
            sb = $signed(b);
            case (op)
              OP_ADD: a = a + b;
              OP_SUB: a = a - b;
              OP_MUL: a = a * b;
              OP_DIV: a = DATA_W'(sa / sb);
              default: a = DATA_W'(sa % sb);
            endcase
            shadow_stack[shadow_depth - 2] = a;
            shadow_depth--;
          end
        end
        OP_NEG: shadow_stack[shadow_depth - 1] = '0 - shadow_stack[shadow_depth - 1];
        OP_RET: begin
          shadow_depth--;
          res.value = shadow_stack[shadow_depth];
          res.returned = 1'b1;
        end
        default: ;
      endcase
    end
    fault_tally[res.fault]++;
    if (res.returned) return_count++;
    outcome_q.push_back(res);
  endfunction

  // Offer one instruction, hold it until accepted, then predict its outcome
  task automatic send_instr(logic [OPC_W-1:0] op, logic [DATA_W-1:0] lit,
                            logic [SLOT_W-1:0] slot);
    int unsigned gap;
    gap = pick_gap(send_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    literal_value_i <= lit;
    slot_index_i <= slot;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    execute_instr(op, lit, slot);
    instr_count++;
  endtask

  // Underflow on every arity, no-ops, wraparound, divide by zero, min / -1 and frame round trip
  task automatic test_directed();
    send_instr(OP_RET, '0, '0);
    send_instr(OP_POP, '0, '0);
    send_instr(OP_ADD, '0, '0);
    send_instr(OP_NEG, '0, '0);
    send_instr(OP_SET, '0, '0);
    send_instr(OP_NOP, WORD_NEG1, '1);
    send_instr(OPC_TOP, WORD_NEG1, '1);
    send_instr(OP_LIT, WORD_MAX, '0);
    send_instr(OP_LIT, 32'd1, '0);
    send_instr(OP_ADD, '0, '0);
    send_instr(OP_GET, '0, '0);
    send_instr(OP_MOD, '0, '0);
    send_instr(OP_POP, '0, '0);
    send_instr(OP_LIT, WORD_NEG1, '0);
    send_instr(OP_DIV, '0, '0);
    send_instr(OP_SET, '0, '1);
    send_instr(OP_GET, '0, '1);
    send_instr(OP_LIT, WORD_NEG1, '0);
    send_instr(OP_MOD, '0, '0);
    send_instr(OP_RET, '0, '0);
    send_instr(OP_GET, '0, '1);
    send_instr(OP_NEG, '0, '0);
    send_instr(OP_LIT, WORD_NEG1, '0);
    send_instr(OP_MUL, '0, '0);
    send_instr(OP_RET, '0, '0);
  endtask

  // Fill the stack to the top, push past it, then unwind
  task automatic test_overflow();
    while (shadow_depth < N_STACK)
      send_instr($urandom_range(0, 3) == 0 ? OP_GET : OP_LIT, pick_word(), pick_slot());
    send_instr(OP_LIT, pick_word(), pick_slot());
    send_instr(OP_GET, '0, pick_slot());
    while (shadow_depth > 0)
      send_instr(OPC_W'($urandom_range(OP_SET, OP_RET)), pick_word(), pick_slot());
  endtask

  // Hold the output off for a long stretch while instructions keep coming
  task automatic test_pressure();
    int unsigned k;
    send_calm = 1'b1;
    hold_cycles_req = HOLD_OFF_CYCLES;
    for (k = 0; k < 12; k++) send_instr(OP_LIT, pick_word(), pick_slot());
    for (k = 0; k < 11; k++) send_instr(OPC_W'($urandom_range(OP_ADD, OP_MOD)), '0, '0);
    while (shadow_depth > 0) send_instr(OP_RET, '0, '0);
    send_calm = 1'b0;
  endtask

  // Random well-formed programs with some noise and bad arity mixed in
  task automatic test_random_programs(int unsigned n_items);
    int unsigned done_items;
    int unsigned r;
    logic [OPC_W-1:0] op;
    done_items = 0;
    while (done_items < n_items) begin
      if ($urandom_range(0, 99) == 0) send_calm = ~send_calm;
      if ($urandom_range(0, 99) == 0) recv_calm = ~recv_calm;
      r = $urandom_range(0, 99);
      if (r < 8) op = OPC_W'($urandom_range(0, (1 << OPC_W) - 1));
      else if (shadow_depth < 2 && r < 70) op = (r < 40) ? OP_LIT : OP_GET;
      else if (shadow_depth > 12) op = OPC_W'($urandom_range(OP_SET, OP_RET));
      else op = OPC_W'($urandom_range(OP_LIT, OP_RET));
      send_instr(op, pick_word(), pick_slot());
      if (op >= OP_LIT && op <= OP_RET) done_items++;
    end
    while (shadow_depth > 0) send_instr(OP_RET, '0, '0);
    send_calm = 1'b0;
    recv_calm = 1'b0;
  endtask

  // Drive output stall: random bursts plus one long requested hold-off
  initial begin : receiver_stall
    int unsigned n;
    forever begin
      @(posedge clk_i);
      if (hold_cycles_req != 0) begin
        n = hold_cycles_req;
        hold_cycles_req = 0;
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!recv_calm && $urandom_range(0, 2) == 0) begin
        n = pick_gap(1'b0);
        if (n != 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string field, longint exp_v, longint act_v);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, exp_v, act_v);
  endtask

  // Compare each result transaction against the oldest prediction
  always @(posedge clk_i) begin : check_results
    outcome_t exp_r;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("unexpected result, returned", -1, returned_o);
      end else begin
        exp_r = outcome_q.pop_front();
        if (returned_o !== exp_r.returned)
          report_mismatch("returned", exp_r.returned, returned_o);
        if (return_value_o !== exp_r.value)
          report_mismatch("return_value", $signed(exp_r.value), return_value_o);
        if (fault_o !== exp_r.fault)
          report_mismatch("fault", exp_r.fault, fault_o);
      end
    end
  end

  initial begin : main_seq
    foreach (shadow_frame[i]) shadow_frame[i] = '0;
    shadow_depth = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_pressure();
    test_random_programs(1150);
    in_valid_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("Ran %0d instructions: %0d returns, %0d underflow, %0d overflow, %0d divide-by-zero",
             instr_count, return_count, fault_tally[FAULT_UNDER], fault_tally[FAULT_OVER],
             fault_tally[FAULT_DIV_ZERO]);
    $display("Stack filled to %0d words once; output held off for %0d cycles once",
             N_STACK, HOLD_OFF_CYCLES);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #10_000_000;
    $display("Timeout with %0d results outstanding", outcome_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
